// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the sprite blit design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define CSB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same, for checks that must hold at every edge, reset included.
`define CSB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== design/csbak_pkg.sv =====
// ----------------------------------------------------------------------------
// csbak_pkg
// Shared types, constants and helpers of the clipped sprite blit.
// ----------------------------------------------------------------------------
package csbak_pkg;

    localparam int DIM_W       = 11;
    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 8;
    localparam int INDEX_W     = 20;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DEF_MAX_DIM = 1024;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SPRITE_LEFT = 3'd0,
        REG_SPRITE_TOP  = 3'd1,
        REG_SPRITE_COLS = 3'd2,
        REG_SPRITE_ROWS = 3'd3,
        REG_SCREEN_COLS = 3'd4,
        REG_SCREEN_ROWS = 3'd5,
        REG_ALPHA_MODE  = 3'd6
    } t_reg_idx;

    localparam logic [COORD_W-1:0] RST_SPRITE_LEFT = '0;
    localparam logic [COORD_W-1:0] RST_SPRITE_TOP  = '0;
    localparam logic [DIM_W-1:0]   RST_SPRITE_COLS = 11'd1;
    localparam logic [DIM_W-1:0]   RST_SPRITE_ROWS = 11'd1;
    localparam logic [DIM_W-1:0]   RST_SCREEN_COLS = 11'd400;
    localparam logic [DIM_W-1:0]   RST_SCREEN_ROWS = 11'd240;
    localparam logic               RST_ALPHA_MODE  = 1'b1;

    // Clamped configuration as seen by the datapath.
    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [DIM_W-1:0]   scols;
        logic [DIM_W-1:0]   srows;
        logic [DIM_W-1:0]   fcols;
        logic [DIM_W-1:0]   frows;
        logic               alpha_mode;
    } t_cfg;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
    } t_pixel;

    // Zero reads as one, anything above max_dim reads as max_dim.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned max_dim);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (32'(v) > max_dim) begin
            return DIM_W'(max_dim);
        end else begin
            return v;
        end
    endfunction

endpackage

// ===== design/clipped_sprite_blit_alpha_key_top.sv =====
// ----------------------------------------------------------------------------
// clipped_sprite_blit_alpha_key_top
// Sprite blit with screen clipping and optional alpha key.
// ----------------------------------------------------------------------------
// Sprite pixels enter one request per clock in raster order and leave as
// framebuffer writes, one result per request, via the input and result registers.
// Throughput is one pixel per clock: the input register and the result
// register each pass a request every cycle unless the output side stalls.
// The row-times-width multiply and index add sit between the two registers.
// A configuration write restarts the sprite at its top left pixel; write
// registers only while no request is in flight.
module clipped_sprite_blit_alpha_key_top import csbak_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COLOR_W-1:0]    i_red,
    input  logic [COLOR_W-1:0]    i_green,
    input  logic [COLOR_W-1:0]    i_blue,
    input  logic [COLOR_W-1:0]    i_alpha,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_write_enable,
    output logic [INDEX_W-1:0]    o_pixel_index,
    output logic [COLOR_W-1:0]    o_out_red,
    output logic [COLOR_W-1:0]    o_out_green,
    output logic [COLOR_W-1:0]    o_out_blue,
    output logic                  o_sprite_done
);

    localparam int CNT_W = $clog2(MAX_DIM);

    t_cfg             cfg;
    logic             restart;
    t_pixel           in_pixel;
    t_pixel           stg_pixel;
    logic             stg_valid;
    logic             stg_done;
    logic [CNT_W-1:0] stg_col;
    logic [CNT_W-1:0] stg_row;
    logic             take;

    assign in_pixel = '{red: i_red, green: i_green, blue: i_blue, alpha: i_alpha};

    csbak_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_restart   (restart)
    );

    csbak_pos #(
        .MAX_DIM (MAX_DIM),
        .CNT_W   (CNT_W)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_restart (restart),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_pixel   (in_pixel),
        .i_take    (take),
        .o_valid   (stg_valid),
        .o_done    (stg_done),
        .o_pixel   (stg_pixel),
        .o_col     (stg_col),
        .o_row     (stg_row)
    );

    csbak_pix #(
        .MAX_DIM (MAX_DIM),
        .CNT_W   (CNT_W)
    ) u_pix (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (stg_valid),
        .i_done         (stg_done),
        .i_pixel        (stg_pixel),
        .i_col          (stg_col),
        .i_row          (stg_row),
        .o_take         (take),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_write_enable (o_write_enable),
        .o_pixel_index  (o_pixel_index),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_sprite_done  (o_sprite_done)
    );

endmodule

// ===== design/csbak_cfg.sv =====
// ----------------------------------------------------------------------------
// csbak_cfg
// Configuration registers with dimension clamping and restart request.
// ----------------------------------------------------------------------------
module csbak_cfg import csbak_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic                  o_restart
);

    logic [COORD_W-1:0] r_left;
    logic [COORD_W-1:0] r_top;
    logic [DIM_W-1:0]   r_scols;
    logic [DIM_W-1:0]   r_srows;
    logic [DIM_W-1:0]   r_fcols;
    logic [DIM_W-1:0]   r_frows;
    logic               r_alpha_mode;

    always_comb begin
        o_restart = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SPRITE_LEFT, REG_SPRITE_TOP, REG_SPRITE_COLS, REG_SPRITE_ROWS,
                REG_SCREEN_COLS, REG_SCREEN_ROWS, REG_ALPHA_MODE: o_restart = 1'b1;
                default: o_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= RST_SPRITE_LEFT;
            r_top        <= RST_SPRITE_TOP;
            r_scols      <= RST_SPRITE_COLS;
            r_srows      <= RST_SPRITE_ROWS;
            r_fcols      <= RST_SCREEN_COLS;
            r_frows      <= RST_SCREEN_ROWS;
            r_alpha_mode <= RST_ALPHA_MODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SPRITE_LEFT: r_left       <= i_cfg_data;
                REG_SPRITE_TOP:  r_top        <= i_cfg_data;
                REG_SPRITE_COLS: r_scols      <= i_cfg_data[DIM_W-1:0];
                REG_SPRITE_ROWS: r_srows      <= i_cfg_data[DIM_W-1:0];
                REG_SCREEN_COLS: r_fcols      <= i_cfg_data[DIM_W-1:0];
                REG_SCREEN_ROWS: r_frows      <= i_cfg_data[DIM_W-1:0];
                REG_ALPHA_MODE:  r_alpha_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.left       = r_left;
    assign o_cfg.top        = r_top;
    assign o_cfg.scols      = clamp_dim(r_scols, MAX_DIM);
    assign o_cfg.srows      = clamp_dim(r_srows, MAX_DIM);
    assign o_cfg.fcols      = clamp_dim(r_fcols, MAX_DIM);
    assign o_cfg.frows      = clamp_dim(r_frows, MAX_DIM);
    assign o_cfg.alpha_mode = r_alpha_mode;

endmodule

// ===== design/csbak_pos.sv =====
// ----------------------------------------------------------------------------
// csbak_pos
// Input register and raster position counters of the sprite.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csbak_pos import csbak_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int CNT_W   = $clog2(MAX_DIM)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_restart,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_pixel           i_pixel,
    input  logic             i_take,
    output logic             o_valid,
    output logic             o_done,
    output t_pixel           o_pixel,
    output logic [CNT_W-1:0] o_col,
    output logic [CNT_W-1:0] o_row
);

    localparam int CMP_W = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;

    logic             r_valid;
    logic             r_done;
    t_pixel           r_pixel;
    logic [CNT_W-1:0] r_pix_col;
    logic [CNT_W-1:0] r_pix_row;
    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic             accept;
    logic             last_col;
    logic             last_row;

    assign o_ready  = !r_valid || i_take;
    assign accept   = i_valid && o_ready;
    assign last_col = (CMP_W'(r_col) + CMP_W'(1)) >= CMP_W'(i_cfg.scols);
    assign last_row = (CMP_W'(r_row) + CMP_W'(1)) >= CMP_W'(i_cfg.srows);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
            if (i_restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + CNT_W'(1);
                end else begin
                    r_col <= r_col + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel   <= i_pixel;
            r_pix_col <= r_col;
            r_pix_row <= r_row;
            r_done    <= last_col && last_row;
        end
    end

    assign o_valid = r_valid;
    assign o_done  = r_done;
    assign o_pixel = r_pixel;
    assign o_col   = r_pix_col;
    assign o_row   = r_pix_row;

    `CSB_ASSERT(a_cnt_in_range, i_clk, i_rst_n,
        (CMP_W'(r_col) < CMP_W'(i_cfg.scols)) && (CMP_W'(r_row) < CMP_W'(i_cfg.srows)),
        "position counter beyond sprite size")
    `CSB_ASSERT(a_wrap_after_last, i_clk, i_rst_n,
        accept && last_col && last_row |=> (r_col == '0) && (r_row == '0),
        "counters did not wrap after final pixel")

endmodule

// ===== design/csbak_pix.sv =====
// ----------------------------------------------------------------------------
// csbak_pix
// Clip, alpha key and framebuffer index, into the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csbak_pix import csbak_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int CNT_W   = $clog2(MAX_DIM)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    input  logic               i_done,
    input  t_pixel             i_pixel,
    input  logic [CNT_W-1:0]   i_col,
    input  logic [CNT_W-1:0]   i_row,
    output logic               o_take,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_write_enable,
    output logic [INDEX_W-1:0] o_pixel_index,
    output logic [COLOR_W-1:0] o_out_red,
    output logic [COLOR_W-1:0] o_out_green,
    output logic [COLOR_W-1:0] o_out_blue,
    output logic               o_sprite_done
);

    localparam int POS_W = ((COORD_W > CNT_W + 1) ? COORD_W : CNT_W + 1) + 1;

    logic               r_valid;
    logic               r_we;
    logic [INDEX_W-1:0] r_index;
    logic [COLOR_W-1:0] r_red;
    logic [COLOR_W-1:0] r_green;
    logic [COLOR_W-1:0] r_blue;
    logic               r_done;

    logic [POS_W-1:0]   sx;
    logic [POS_W-1:0]   sy;
    logic               row_vis;
    logic               col_vis;
    logic [2*DIM_W-1:0] row_base;
    logic               n_we;
    logic [INDEX_W-1:0] n_index;

    // Screen coordinates, sign extended sprite origin plus counter.
    assign sx = {{(POS_W-COORD_W){i_cfg.left[COORD_W-1]}}, i_cfg.left}
              + {{(POS_W-CNT_W){1'b0}}, i_col};
    assign sy = {{(POS_W-COORD_W){i_cfg.top[COORD_W-1]}}, i_cfg.top}
              + {{(POS_W-CNT_W){1'b0}}, i_row};

    assign row_vis  = !sy[POS_W-1] && (sy < POS_W'(i_cfg.frows));
    assign col_vis  = !sx[POS_W-1] && (sx < POS_W'(i_cfg.fcols));
    assign row_base = sy[DIM_W-1:0] * i_cfg.fcols;
    assign n_we     = row_vis && col_vis && (!i_cfg.alpha_mode || (i_pixel.alpha != '0));
    assign n_index  = row_base[INDEX_W-1:0] + INDEX_W'(sx[DIM_W-1:0]);

    assign o_take = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_we    <= n_we;
            r_index <= n_we ? n_index : '0;
            r_red   <= n_we ? i_pixel.red : '0;
            r_green <= n_we ? i_pixel.green : '0;
            r_blue  <= n_we ? i_pixel.blue : '0;
            r_done  <= i_done;
        end
    end

    assign o_valid        = r_valid;
    assign o_write_enable = r_we;
    assign o_pixel_index  = r_index;
    assign o_out_red      = r_red;
    assign o_out_green    = r_green;
    assign o_out_blue     = r_blue;
    assign o_sprite_done  = r_done;

    `CSB_ASSERT(a_stage_moves, i_clk, i_rst_n,
        i_valid && o_take |=> o_valid,
        "request lost between input and result register")
    `CSB_ASSERT(a_masked_zero, i_clk, i_rst_n,
        o_valid && !o_write_enable |-> (o_pixel_index == '0) && (o_out_red == '0)
            && (o_out_green == '0) && (o_out_blue == '0),
        "suppressed write carries nonzero payload")

endmodule
